// File: rtl/ffrm_pkg.sv
// package for the force feedback rumble mapper: codes, constants, record types
// and the impact level tables built at elaboration
// depends on nothing
`default_nettype none

package ffrm_pkg;

	localparam int LEVEL_W       = 16;
	localparam int STRENGTH_W    = 8;
	localparam int EFFECT_W      = 3;
	localparam int POS_W         = 16;
	localparam int HOLD_W        = 4;

	localparam int LEVEL_CEILING = 65535;
	localparam int DRIVE_FULL    = 255;
	localparam int DEADZONE      = 7000;
	localparam int HOLD_FRAMES   = 12;
	localparam int AXIS_MAX      = 32767;

	localparam int IMPACT_MIN    = LEVEL_CEILING / 4;
	localparam int IMPACT_SPAN   = LEVEL_CEILING - IMPACT_MIN;
	localparam int CORNER_PEAK   = LEVEL_CEILING * 2 / 5;
	localparam int CORNER_SPAN   = AXIS_MAX - DEADZONE;
	localparam int OVER_W        = $clog2(CORNER_SPAN + 1);
	localparam int DEFL_W        = POS_W + 1;

	// cornering = floor(over * peak / span) as (over * mul) >> shift, exact over the span
	localparam int CORNER_SHIFT  = 30;
	localparam logic [63:0] CORNER_MUL_WIDE =
		((64'(CORNER_PEAK) << CORNER_SHIFT) + 64'(CORNER_SPAN) - 64'd1) / 64'(CORNER_SPAN);
	localparam int CORNER_MUL_W  = 31;
	localparam logic [CORNER_MUL_W-1:0] CORNER_MUL = CORNER_MUL_WIDE[CORNER_MUL_W-1:0];
	localparam int CORNER_PROD_W = OVER_W + CORNER_MUL_W;

	typedef enum logic [0:0] {
		REQ_CMD   = 1'b0,
		REQ_FRAME = 1'b1
	} req_kind_t;

	typedef enum logic [EFFECT_W-1:0] {
		EFF_OTHER      = 3'd0,
		EFF_SPRING     = 3'd1,
		EFF_VIBRATE    = 3'd2,
		EFF_PUSH_LEFT  = 3'd3,
		EFF_PUSH_RIGHT = 3'd4,
		EFF_LATCHED    = 3'd5
	} effect_t;

	typedef enum logic [1:0] {
		DIR_NONE  = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_RIGHT = 2'd2
	} dir_t;

	typedef struct packed {
		logic [EFFECT_W-1:0]   effect;
		logic                  held;
		logic [STRENGTH_W-1:0] strength;
	} latch_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] target;
		dir_t               dir_next;
	} frame_eval_t;

	typedef logic [LEVEL_W-1:0] level_table_t [2**STRENGTH_W];

	function automatic level_table_t build_impact_table();
		level_table_t t;
		for (int i = 0; i < 2**STRENGTH_W; i++) begin
			t[i] = LEVEL_W'(IMPACT_MIN + (IMPACT_SPAN * i) / DRIVE_FULL);
		end
		return t;
	endfunction

	function automatic level_table_t build_boost_table();
		level_table_t t;
		int           v;
		for (int i = 0; i < 2**STRENGTH_W; i++) begin
			v = (IMPACT_MIN + (IMPACT_SPAN * i) / DRIVE_FULL) * 3 / 2;
			t[i] = (v > LEVEL_CEILING) ? LEVEL_W'(LEVEL_CEILING) : LEVEL_W'(v);
		end
		return t;
	endfunction

	localparam level_table_t IMPACT_TABLE = build_impact_table();
	localparam level_table_t BOOST_TABLE  = build_boost_table();

endpackage

`default_nettype wire

// File: rtl/ffrm_frame_calc.sv
// frame evaluation: impact from the latched command, cornering from deflection,
// target level and next push direction
// depends on ffrm_pkg
`default_nettype none

module ffrm_frame_calc (
	input  var ffrm_pkg::latch_t               latch,
	input  var ffrm_pkg::dir_t                 dir,
	input  var logic [ffrm_pkg::POS_W-1:0]     pos,
	output var ffrm_pkg::frame_eval_t          eval
);

	logic                                  is_push;
	logic                                  is_impact;
	ffrm_pkg::dir_t                        push_dir;
	ffrm_pkg::dir_t                        dir_next;
	logic [ffrm_pkg::LEVEL_W-1:0]          impact;
	logic [ffrm_pkg::DEFL_W-1:0]           defl;
	logic [ffrm_pkg::DEFL_W-1:0]           over_raw;
	logic [ffrm_pkg::OVER_W-1:0]           over;
	logic [ffrm_pkg::CORNER_PROD_W-1:0]    prod;
	logic [ffrm_pkg::LEVEL_W-1:0]          cornering;

	always_comb begin
		is_push   = (latch.effect == ffrm_pkg::EFF_PUSH_LEFT) ||
		            (latch.effect == ffrm_pkg::EFF_PUSH_RIGHT);
		is_impact = (latch.strength != '0) && !latch.held &&
		            (is_push || (latch.effect == ffrm_pkg::EFF_VIBRATE));
		push_dir  = (latch.effect == ffrm_pkg::EFF_PUSH_LEFT) ? ffrm_pkg::DIR_LEFT :
		            ffrm_pkg::DIR_RIGHT;
		impact   = '0;
		dir_next = dir;
		if (is_impact) begin
			impact = ffrm_pkg::IMPACT_TABLE[latch.strength];
			if (is_push && (push_dir != dir)) begin
				impact   = ffrm_pkg::BOOST_TABLE[latch.strength];
				dir_next = push_dir;
			end
		end
	end

	// magnitude of the axis, full negative deflection counts one past the positive end
	always_comb begin
		defl     = pos[ffrm_pkg::POS_W-1] ?
		           ffrm_pkg::DEFL_W'((1 << ffrm_pkg::POS_W) - {1'b0, pos}) : {1'b0, pos};
		over_raw = defl - ffrm_pkg::DEFL_W'(ffrm_pkg::DEADZONE);
		if (defl <= ffrm_pkg::DEFL_W'(ffrm_pkg::DEADZONE)) begin
			over = '0;
		end else if (over_raw > ffrm_pkg::DEFL_W'(ffrm_pkg::CORNER_SPAN)) begin
			over = ffrm_pkg::OVER_W'(ffrm_pkg::CORNER_SPAN);
		end else begin
			over = over_raw[ffrm_pkg::OVER_W-1:0];
		end
		prod      = ffrm_pkg::CORNER_PROD_W'(over) * ffrm_pkg::CORNER_PROD_W'(ffrm_pkg::CORNER_MUL);
		cornering = prod[ffrm_pkg::CORNER_SHIFT +: ffrm_pkg::LEVEL_W];
	end

	assign eval = '{target: ((impact > cornering) ? impact : cornering), dir_next: dir_next};

endmodule

`default_nettype wire

// File: rtl/force_feedback_rumble_mapper.sv
// a frame tick's rumble pair is captured in the input register at acceptance and moves into the
// result register once that register holds no unaccepted result; commands give no result
// throughput: one request per clock, ready drops only while a frame result waits
// asynchronous active-low reset clears the latch, level, hold, sent pair and
// steering_present; depends on ffrm_pkg and ffrm_frame_calc
`default_nettype none

module force_feedback_rumble_mapper (
	input  var logic                                 clk,
	input  var logic                                 arst_n,
	input  var logic                                 cfg_we,
	input  var logic                                 cfg_wdata,
	input  var logic                                 req_valid,
	output var logic                                 req_ready,
	input  var logic                                 req_type,
	input  var logic [ffrm_pkg::EFFECT_W-1:0]        cmd_effect,
	input  var logic                                 cmd_held,
	input  var logic [ffrm_pkg::STRENGTH_W-1:0]      cmd_strength,
	input  var logic signed [ffrm_pkg::POS_W-1:0]    steering_pos,
	input  var logic                                 rumble_enabled,
	output var logic                                 rsp_valid,
	input  var logic                                 rsp_ready,
	output var logic [ffrm_pkg::LEVEL_W-1:0]         strong_level,
	output var logic [ffrm_pkg::LEVEL_W-1:0]         weak_level,
	output var logic                                 level_changed
);

	// input register
	logic                                  valid_s1;
	logic                                  req_type_s1;
	logic [ffrm_pkg::EFFECT_W-1:0]         effect_s1;
	logic                                  held_s1;
	logic [ffrm_pkg::STRENGTH_W-1:0]       strength_s1;
	logic [ffrm_pkg::POS_W-1:0]            pos_s1;
	logic                                  enabled_s1;

	// mapping state
	logic                                  steering_present_q;
	ffrm_pkg::latch_t                      latch_q, latch_d;
	logic [ffrm_pkg::LEVEL_W-1:0]          level_q, level_d;
	ffrm_pkg::dir_t                        dir_q, dir_d;
	logic [ffrm_pkg::HOLD_W-1:0]           hold_q, hold_d;
	logic [ffrm_pkg::LEVEL_W-1:0]          sent_strong_q;
	logic [ffrm_pkg::LEVEL_W-1:0]          sent_weak_q;

	// result register
	logic                                  rsp_valid_q;
	logic [ffrm_pkg::LEVEL_W-1:0]          strong_q;
	logic [ffrm_pkg::LEVEL_W-1:0]          weak_q;
	logic                                  changed_q;

	logic                                  rsp_free;
	logic                                  is_frame_s1;
	logic                                  done_s1;
	logic                                  skip_cmd;
	logic                                  active;
	logic [ffrm_pkg::LEVEL_W-1:0]          strong_d;
	logic [ffrm_pkg::LEVEL_W-1:0]          weak_d;
	logic                                  changed_d;
	ffrm_pkg::frame_eval_t                 eval;

	assign rsp_free    = !rsp_valid_q || rsp_ready;
	assign is_frame_s1 = (req_type_s1 == ffrm_pkg::REQ_FRAME);
	assign done_s1     = valid_s1 && (!is_frame_s1 || rsp_free);
	assign req_ready   = !valid_s1 || done_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_type_s1 <= req_type;
			effect_s1   <= cmd_effect;
			held_s1     <= cmd_held;
			strength_s1 <= cmd_strength;
			pos_s1      <= $unsigned(steering_pos);
			enabled_s1  <= rumble_enabled;
		end
	end

	ffrm_frame_calc u_frame_calc (
		.latch (latch_q),
		.dir   (dir_q),
		.pos   (pos_s1),
		.eval  (eval)
	);

	always_comb begin
		skip_cmd = (effect_s1 == ffrm_pkg::EFF_OTHER) ||
		           (effect_s1 > ffrm_pkg::EFF_LATCHED) ||
		           ((effect_s1 == ffrm_pkg::EFF_SPRING) && !held_s1 && latch_q.held);
		active   = enabled_s1 && steering_present_q;

		latch_d  = latch_q;
		level_d  = level_q;
		dir_d    = dir_q;
		hold_d   = hold_q;
		strong_d = '0;
		weak_d   = '0;

		if (!is_frame_s1) begin
			if (!skip_cmd) begin
				latch_d.effect   = effect_s1;
				latch_d.held     = held_s1;
				latch_d.strength = (strength_s1 > ffrm_pkg::STRENGTH_W'(ffrm_pkg::DRIVE_FULL)) ?
				                   ffrm_pkg::STRENGTH_W'(ffrm_pkg::DRIVE_FULL) : strength_s1;
			end
		end else if (!active) begin
			latch_d = '0;
			level_d = '0;
			dir_d   = ffrm_pkg::DIR_NONE;
			hold_d  = '0;
		end else begin
			dir_d = eval.dir_next;
			if (eval.target != '0) begin
				level_d = eval.target;
				hold_d  = ffrm_pkg::HOLD_W'(ffrm_pkg::HOLD_FRAMES);
			end else if (hold_q != '0) begin
				hold_d = hold_q - 1'b1;
				if (hold_q == ffrm_pkg::HOLD_W'(1)) begin
					level_d = '0;
					dir_d   = ffrm_pkg::DIR_NONE;
				end
			end
			strong_d = level_d;
			weak_d   = level_d >> 1;
		end

		changed_d = (strong_d != sent_strong_q) || (weak_d != sent_weak_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steering_present_q <= 1'b0;
			latch_q            <= '0;
			level_q            <= '0;
			dir_q              <= ffrm_pkg::DIR_NONE;
			hold_q             <= '0;
			sent_strong_q      <= '0;
			sent_weak_q        <= '0;
		end else begin
			if (cfg_we) begin
				steering_present_q <= cfg_wdata;
			end
			if (done_s1) begin
				latch_q <= latch_d;
				level_q <= level_d;
				dir_q   <= dir_d;
				hold_q  <= hold_d;
				if (is_frame_s1) begin
					sent_strong_q <= strong_d;
					sent_weak_q   <= weak_d;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done_s1 && is_frame_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1 && is_frame_s1) begin
			strong_q  <= strong_d;
			weak_q    <= weak_d;
			changed_q <= changed_d;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign strong_level  = strong_q;
	assign weak_level    = weak_q;
	assign level_changed = changed_q;

endmodule

`default_nettype wire

// File: rtl/ffrm_checker.sv
// port-level checks for the rumble mapper and the bind that attaches them
// depends on ffrm_pkg and force_feedback_rumble_mapper
`default_nettype none

module ffrm_checker (
	input  var logic                                 clk,
	input  var logic                                 arst_n,
	input  var logic                                 req_ready,
	input  var logic                                 rsp_valid,
	input  var logic                                 rsp_ready,
	input  var logic [ffrm_pkg::LEVEL_W-1:0]         strong_level,
	input  var logic [ffrm_pkg::LEVEL_W-1:0]         weak_level,
	input  var logic                                 level_changed
);

	// weak motor always runs at half the strong motor
	a_weak_half: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (weak_level == (strong_level >> 1)))
		else $error("weak level is not half of strong level");

	// requests back up only behind a stalled result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (rsp_valid && !rsp_ready))
		else $error("request stalled without a stalled result");

	// a stalled result holds its pair and flag
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
			(rsp_valid && $stable(strong_level) && $stable(weak_level) && $stable(level_changed)))
		else $error("stalled result changed");

	// a result with no change repeats the pair just sent before it
	a_unchanged: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready) ##1 (rsp_valid && !level_changed) |->
			(strong_level == $past(strong_level)))
		else $error("unchanged flag on a new level");

endmodule

bind force_feedback_rumble_mapper ffrm_checker u_ffrm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_ready     (req_ready),
	.rsp_valid     (rsp_valid),
	.rsp_ready     (rsp_ready),
	.strong_level  (strong_level),
	.weak_level    (weak_level),
	.level_changed (level_changed)
);

`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench for force_feedback_rumble_mapper: drives command and frame
// requests, predicts each rumble pair in a scoreboard class and compares in order
// depends on ffrm_pkg and the force_feedback_rumble_mapper rtl
`timescale 1ns / 1ps

module testbench;
	import ffrm_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_STALL     = 300;
	localparam int SETTLE_CYCLES  = 4;
	localparam int REPORT_LIMIT   = 10;

	typedef struct {
		req_kind_t             kind;
		logic [EFFECT_W-1:0]   effect;
		logic                  held;
		logic [STRENGTH_W-1:0] strength;
		logic [POS_W-1:0]      pos;
		logic                  enabled;
	} rumble_req_t;

	typedef struct {
		logic [LEVEL_W-1:0] strong_val;
		logic [LEVEL_W-1:0] weak_val;
		logic               changed;
	} rumble_pair_t;

	class rumble_scoreboard;
		bit                    present;
		logic [EFFECT_W-1:0]   latch_effect;
		logic                  latch_held;
		logic [STRENGTH_W-1:0] latch_strength;
		int unsigned           level;
		dir_t                  direction;
		int unsigned           hold_left;
		logic [LEVEL_W-1:0]    sent_strong;
		logic [LEVEL_W-1:0]    sent_weak;
		rumble_pair_t          pending_pairs[$];
		int                    mismatches;

		function void clear_mapping();
			latch_effect   = EFF_OTHER;
			latch_held     = 1'b0;
			latch_strength = '0;
			level          = 0;
			direction      = DIR_NONE;
			hold_left      = 0;
		endfunction

		function void reset_state();
			present     = 1'b0;
			sent_strong = '0;
			sent_weak   = '0;
			mismatches  = 0;
			clear_mapping();
		endfunction

		function void push_pair(logic [LEVEL_W-1:0] s, logic [LEVEL_W-1:0] w);
			rumble_pair_t p;
			p.strong_val = s;
			p.weak_val   = w;
			p.changed    = (s != sent_strong) || (w != sent_weak);
			sent_strong = s;
			sent_weak   = w;
			pending_pairs.push_back(p);
		endfunction

		function void note_request(rumble_req_t r);
			int unsigned impact;
			int unsigned corner;
			int unsigned deflection;
			int unsigned over;
			int unsigned span;
			int unsigned target;
			int unsigned strong_lvl;
			dir_t        heading;
			bit          is_push;
			if (r.kind == REQ_CMD) begin
				if (r.effect == EFF_OTHER || r.effect > EFF_LATCHED)
					return;
				if (r.effect == EFF_SPRING && !r.held && latch_held)
					return;
				latch_effect   = r.effect;
				latch_held     = r.held;
				latch_strength = (r.strength > DRIVE_FULL) ? STRENGTH_W'(DRIVE_FULL) : r.strength;
				return;
			end
			if (!r.enabled || !present) begin
				clear_mapping();
				push_pair('0, '0);
				return;
			end
			impact  = 0;
			is_push = (latch_effect == EFF_PUSH_LEFT) || (latch_effect == EFF_PUSH_RIGHT);
			if (latch_strength != 0 && !latch_held && (is_push || latch_effect == EFF_VIBRATE)) begin
				impact = LEVEL_CEILING / 4
					+ (LEVEL_CEILING - LEVEL_CEILING / 4) * latch_strength / DRIVE_FULL;
				if (is_push) begin
					heading = (latch_effect == EFF_PUSH_LEFT) ? DIR_LEFT : DIR_RIGHT;
					if (heading != direction) begin
						impact = impact * 3 / 2;
						if (impact > LEVEL_CEILING)
							impact = LEVEL_CEILING;
						direction = heading;
					end
				end
			end
			deflection = r.pos[POS_W-1] ? (32'h10000 - r.pos) : r.pos;
			corner     = 0;
			span       = AXIS_MAX - DEADZONE;
			if (deflection > DEADZONE) begin
				over = deflection - DEADZONE;
				if (over > span)
					over = span;
				corner = (LEVEL_CEILING * 2 / 5) * over / span;
			end
			target = (impact > corner) ? impact : corner;
			if (target != 0) begin
				level     = target;
				hold_left = HOLD_FRAMES;
			end else if (hold_left != 0) begin
				hold_left--;
				if (hold_left == 0) begin
					level     = 0;
					direction = DIR_NONE;
				end
			end
			strong_lvl = (level > LEVEL_CEILING) ? LEVEL_CEILING : level;
			push_pair(strong_lvl[LEVEL_W-1:0], strong_lvl[LEVEL_W-1:0] / 2);
		endfunction

		function void log_mismatch(string msg);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%s", msg);
		endfunction

		function void check_pair(logic [LEVEL_W-1:0] s, logic [LEVEL_W-1:0] w, logic c);
			rumble_pair_t e;
			if (pending_pairs.size() == 0) begin
				log_mismatch($sformatf("unexpected rumble pair strong=%0d weak=%0d changed=%0b",
					s, w, c));
				return;
			end
			e = pending_pairs.pop_front();
			if (s !== e.strong_val || w !== e.weak_val || c !== e.changed)
				log_mismatch($sformatf({"rumble pair mismatch: expected %0d/%0d/%0b",
					", got %0d/%0d/%0b"}, e.strong_val, e.weak_val, e.changed, s, w, c));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic                  cfg_wdata;
	logic                  req_valid;
	logic                  req_ready;
	logic                  req_type;
	logic [EFFECT_W-1:0]   cmd_effect;
	logic                  cmd_held;
	logic [STRENGTH_W-1:0] cmd_strength;
	logic [POS_W-1:0]      steering_pos;
	logic                  rumble_enabled;
	logic                  rsp_valid;
	logic                  rsp_ready;
	logic [LEVEL_W-1:0]    strong_level;
	logic [LEVEL_W-1:0]    weak_level;
	logic                  level_changed;

	rumble_scoreboard sb;
	bit               idling_on = 1'b1;
	bit               long_stall_due = 1'b0;

	force_feedback_rumble_mapper uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req_type      (req_type),
		.cmd_effect    (cmd_effect),
		.cmd_held      (cmd_held),
		.cmd_strength  (cmd_strength),
		.steering_pos  (steering_pos),
		.rumble_enabled(rumble_enabled),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.strong_level  (strong_level),
		.weak_level    (weak_level),
		.level_changed (level_changed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic rumble_req_t cmd_req(logic [EFFECT_W-1:0] effect, logic held,
		logic [STRENGTH_W-1:0] strength);
		rumble_req_t r;
		r.kind     = REQ_CMD;
		r.effect   = effect;
		r.held     = held;
		r.strength = strength;
		r.pos      = POS_W'($urandom);
		r.enabled  = 1'($urandom);
		return r;
	endfunction

	function automatic rumble_req_t frame_req(logic [POS_W-1:0] pos, logic enabled);
		rumble_req_t r;
		r.kind     = REQ_FRAME;
		r.effect   = EFFECT_W'($urandom);
		r.held     = 1'($urandom);
		r.strength = STRENGTH_W'($urandom);
		r.pos      = pos;
		r.enabled  = enabled;
		return r;
	endfunction

	function automatic logic [POS_W-1:0] quiet_pos();
		return POS_W'(int'($urandom_range(0, 2 * DEADZONE)) - DEADZONE);
	endfunction

	function automatic rumble_req_t random_request();
		logic [EFFECT_W-1:0]   effect;
		logic [STRENGTH_W-1:0] strength;
		logic [POS_W-1:0]      pos;
		int                    pick;
		if ($urandom_range(0, 99) < 35) begin
			pick = $urandom_range(0, 15);
			if (pick < 13)
				effect = EFFECT_W'($urandom_range(EFF_SPRING, EFF_LATCHED));
			else if (pick == 13)
				effect = EFF_OTHER;
			else
				effect = EFFECT_W'($urandom_range(EFF_LATCHED + 1, 7));
			pick = $urandom_range(0, 9);
			strength = (pick == 0) ? '0 : (pick == 1) ? '1 : STRENGTH_W'($urandom);
			return cmd_req(effect, $urandom_range(0, 3) == 0, strength);
		end
		pick = $urandom_range(0, 9);
		case (pick)
			0: pos = '0;
			1: begin
				case ($urandom_range(0, 5))
					0: pos = 16'h8000;
					1: pos = 16'h7fff;
					2: pos = POS_W'(DEADZONE);
					3: pos = POS_W'(-DEADZONE);
					4: pos = POS_W'(DEADZONE + 1);
					default: pos = POS_W'(-DEADZONE - 1);
				endcase
			end
			2, 3, 4, 5: pos = quiet_pos();
			default: pos = POS_W'($urandom);
		endcase
		return frame_req(pos, $urandom_range(0, 19) != 0);
	endfunction

	task automatic send_request(input rumble_req_t r);
		@(negedge clk);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		req_valid      <= 1'b1;
		req_type       <= r.kind;
		cmd_effect     <= r.effect;
		cmd_held       <= r.held;
		cmd_strength   <= r.strength;
		steering_pos   <= r.pos;
		rumble_enabled <= r.enabled;
		do
			@(posedge clk);
		while (!req_ready);
		sb.note_request(r);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_present(input logic value);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.present = value;
	endtask

	task automatic run_random(input int count);
		int sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 24) == 0) begin
				// held command stops impacts so the hold can run out
				send_request(cmd_req(EFFECT_W'($urandom_range(EFF_SPRING, EFF_LATCHED)), 1'b1,
					STRENGTH_W'($urandom)));
				repeat ($urandom_range(HOLD_FRAMES + 1, HOLD_FRAMES + 3))
					send_request(frame_req(quiet_pos(), 1'b1));
				sent += HOLD_FRAMES + 2;
			end else begin
				send_request(random_request());
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_pair(strong_level, weak_level, level_changed);
	end

	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_stall_due) begin
				long_stall_due = 1'b0;
				rsp_ready <= 1'b0;
				repeat (LONG_STALL) @(negedge clk);
				rsp_ready <= 1'b1;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("force_feedback_rumble_mapper regression: fail");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = 1'b0;
		req_valid      = 1'b0;
		req_type       = REQ_CMD;
		cmd_effect     = EFF_OTHER;
		cmd_held       = 1'b0;
		cmd_strength   = '0;
		steering_pos   = '0;
		rumble_enabled = 1'b0;
		sb = new;
		sb.reset_state();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// no steering after reset: frames give zero and drop the latch
		send_request(cmd_req(EFF_PUSH_LEFT, 1'b0, '1));
		send_request(frame_req(16'h7fff, 1'b1));
		write_present(1'b1);
		send_request(cmd_req(EFF_PUSH_LEFT, 1'b0, '1));
		send_request(frame_req('0, 1'b1));
		send_request(frame_req('0, 1'b1));
		send_request(cmd_req(EFF_PUSH_RIGHT, 1'b0, '0));
		send_request(frame_req(16'h8000, 1'b1));
		send_request(frame_req(POS_W'(DEADZONE), 1'b1));
		send_request(frame_req(POS_W'(DEADZONE + 1), 1'b1));
		send_request(cmd_req(EFF_SPRING, 1'b1, 8'd100));
		send_request(cmd_req(EFF_SPRING, 1'b0, 8'd50));
		send_request(cmd_req(EFF_OTHER, 1'b0, 8'd200));
		send_request(cmd_req(EFFECT_W'(EFF_LATCHED + 1), 1'b0, 8'd90));
		send_request(cmd_req(EFFECT_W'(EFF_LATCHED + 2), 1'b0, 8'd90));
		send_request(frame_req(POS_W'(-DEADZONE - 1), 1'b1));
		send_request(cmd_req(EFF_VIBRATE, 1'b0, 8'd128));
		send_request(frame_req('0, 1'b1));
		send_request(cmd_req(EFF_LATCHED, 1'b0, 8'd200));
		send_request(frame_req(16'h7fff, 1'b1));
		send_request(cmd_req(EFF_PUSH_RIGHT, 1'b0, 8'd1));
		send_request(frame_req(POS_W'(-DEADZONE), 1'b1));
		send_request(cmd_req(EFF_PUSH_LEFT, 1'b0, 8'd200));
		send_request(frame_req('0, 1'b0));
		send_request(frame_req('0, 1'b0));

		run_random(200);
		long_stall_due = 1'b1;
		run_random(300);
		write_present(1'b0);
		run_random(150);
		write_present(1'b1);
		run_random(400);
		wait_idle();
		idling_on = 1'b0;
		run_random(180);

		wait_idle();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_pairs.size() == 0)
			$display("force_feedback_rumble_mapper regression: pass");
		else
			$display("force_feedback_rumble_mapper regression: fail");
		$finish;
	end

endmodule
